FILE: hw/rtl/qfd_pkg.sv
// Shared types, codes and default sizes for the queue with delete by value.
package qfd_pkg;

  // Default storage sizes.
  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;

  // Field widths of the request and response payloads.
  localparam int KIND_W   = 2;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 5;

  // Operation codes.
  localparam logic [KIND_W-1:0] KIND_ENQ = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DEQ = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DEL = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  // One request.
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] item_value;
  } req_t;

  // One response.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  out_value;
    logic [LEN_W-1:0]    length;
  } rsp_t;

endpackage

FILE: hw/rtl/qfd_rsp_reg.sv
// Response output register that decouples the engine from the response stall.
module qfd_rsp_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  qfd_pkg::rsp_t load_data,
  output logic          free,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output qfd_pkg::rsp_t rsp
);

  // The register can take a new response when empty or when its content leaves now.
  assign free = !rsp_valid || !rsp_stall;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  // Payload holds while stalled.
  always_ff @(posedge clk) begin
    if (load) begin
      rsp <= load_data;
    end
  end

endmodule

FILE: hw/rtl/fifo_queue_with_delete_by_value_top.sv
// Top level of the ordered queue with enqueue, dequeue and delete by value.
//
// Requests arrive on req (kind, item_value) under req_valid / req_stall, and
// each produces exactly one response on rsp (status, out_value, length) under
// rsp_valid / rsp_stall. Transfers happen on a rising edge with valid high and
// stall low.
// The queue lives in a circular buffer held in one synchronous RAM with a
// registered read; a sequencer works on one request at a time.
// Enqueue, failing dequeue, delete on an empty queue and the ignored kind 3
// go from acceptance to the done state and then to the response register; a
// successful dequeue first waits in a read state for the RAM word, and any other
// delete makes one RAM read per held entry, with the compare and the close-up
// write of the later entries overlapped with the reads. The RAM read port sets
// the delete time.
// A new request is taken when the sequencer is idle, even while the previous
// response still waits in the output register; if the receiver stalls, the
// finished response waits in the sequencer until the register frees up.
// Reset empties the queue at once (no clearing pass); stored words are only
// read below the current length.
module fifo_queue_with_delete_by_value_top #(
  parameter int DEPTH      = qfd_pkg::DEPTH,
  parameter int DATA_WIDTH = qfd_pkg::DATA_WIDTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  qfd_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output qfd_pkg::rsp_t rsp
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DEQ  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  // Queue storage.
  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic                  mem_we;
  logic [AW-1:0]         mem_wa;
  logic [DATA_WIDTH-1:0] mem_wd;
  logic                  mem_re;
  logic [AW-1:0]         mem_ra;
  logic [DATA_WIDTH-1:0] rdata;

  // Control state.
  logic [1:0]    state, state_next;
  logic [AW-1:0] head, head_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] rd_pos, rd_pos_next;
  logic          cmp_vld, cmp_vld_next;
  logic [AW-1:0] cmp_pos, cmp_pos_next;
  logic          found, found_next;

  // Operand and staged result.
  logic [DATA_WIDTH-1:0]        op_value, op_value_next;
  logic [qfd_pkg::STATUS_W-1:0] res_status, res_status_next;
  logic [DATA_WIDTH-1:0]        res_value, res_value_next;

  logic          accept;
  logic          out_free;
  logic          out_load;
  qfd_pkg::rsp_t out_data;
  logic [63:0]   wide_in;
  logic [63:0]   wide_out;
  logic [63:0]   wide_len;
  logic [DATA_WIDTH-1:0] in_value;

  // Physical RAM address of a position counted from the head.
  function automatic logic [AW-1:0] wrap(input logic [AW-1:0] base, input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (AW+1)'(DEPTH)) begin
      return AW'(sum - (AW+1)'(DEPTH));
    end
    return sum[AW-1:0];
  endfunction

  assign wide_in  = {32'b0, req.item_value};
  assign in_value = wide_in[DATA_WIDTH-1:0];

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;

  // RAM with one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata <= mem[mem_ra];
    end
  end

  // Sequencer.
  always_comb begin
    state_next      = state;
    head_next       = head;
    count_next      = count;
    rd_pos_next     = rd_pos;
    cmp_vld_next    = cmp_vld;
    cmp_pos_next    = cmp_pos;
    found_next      = found;
    op_value_next   = op_value;
    res_status_next = res_status;
    res_value_next  = res_value;
    mem_we          = 1'b0;
    mem_wa          = '0;
    mem_wd          = '0;
    mem_re          = 1'b0;
    mem_ra          = '0;
    out_load        = 1'b0;

    case (state)
      S_IDLE: begin
        if (accept) begin
          res_status_next = qfd_pkg::ST_OK;
          res_value_next  = '0;
          state_next      = S_DONE;
          case (req.kind)
            qfd_pkg::KIND_ENQ: begin
              if (count == CW'(DEPTH)) begin
                res_status_next = qfd_pkg::ST_FULL;
              end else begin
                mem_we     = 1'b1;
                mem_wa     = wrap(head, count[AW-1:0]);
                mem_wd     = in_value;
                count_next = count + CW'(1);
              end
            end
            qfd_pkg::KIND_DEQ: begin
              if (count == '0) begin
                res_status_next = qfd_pkg::ST_EMPTY;
              end else begin
                mem_re     = 1'b1;
                mem_ra     = head;
                state_next = S_DEQ;
              end
            end
            qfd_pkg::KIND_DEL: begin
              if (count == '0) begin
                res_status_next = qfd_pkg::ST_NOT_FOUND;
              end else begin
                op_value_next = in_value;
                rd_pos_next   = '0;
                cmp_vld_next  = 1'b0;
                found_next    = 1'b0;
                state_next    = S_SCAN;
              end
            end
            default: begin
              res_status_next = qfd_pkg::ST_OK;
            end
          endcase
        end
      end

      S_DEQ: begin
        res_value_next = rdata;
        head_next      = wrap(head, AW'(1));
        count_next     = count - CW'(1);
        state_next     = S_DONE;
      end

      S_SCAN: begin
        // Read the next position while the previous one is compared.
        if (rd_pos < count) begin
          mem_re       = 1'b1;
          mem_ra       = wrap(head, rd_pos[AW-1:0]);
          rd_pos_next  = rd_pos + CW'(1);
          cmp_vld_next = 1'b1;
          cmp_pos_next = rd_pos[AW-1:0];
        end else begin
          cmp_vld_next = 1'b0;
        end
        // Past the match, every entry moves one place toward the head.
        if (cmp_vld) begin
          if (found) begin
            mem_we = 1'b1;
            mem_wa = wrap(head, cmp_pos - AW'(1));
            mem_wd = rdata;
          end else if (rdata == op_value) begin
            found_next = 1'b1;
          end
          if (CW'(cmp_pos) == count - CW'(1)) begin
            if (found_next) begin
              count_next      = count - CW'(1);
              res_status_next = qfd_pkg::ST_OK;
            end else begin
              res_status_next = qfd_pkg::ST_NOT_FOUND;
            end
            state_next = S_DONE;
          end
        end
      end

      S_DONE: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      head    <= '0;
      count   <= '0;
      rd_pos  <= '0;
      cmp_vld <= 1'b0;
      found   <= 1'b0;
    end else begin
      state   <= state_next;
      head    <= head_next;
      count   <= count_next;
      rd_pos  <= rd_pos_next;
      cmp_vld <= cmp_vld_next;
      found   <= found_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cmp_pos    <= cmp_pos_next;
    op_value   <= op_value_next;
    res_status <= res_status_next;
    res_value  <= res_value_next;
  end

  // Response payload.
  assign wide_out = 64'(res_value);
  assign wide_len = 64'(count);
  always_comb begin
    out_data.status    = res_status;
    out_data.out_value = wide_out[qfd_pkg::VALUE_W-1:0];
    out_data.length    = wide_len[qfd_pkg::LEN_W-1:0];
  end

  qfd_rsp_reg u_rsp_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (out_load),
    .load_data (out_data),
    .free      (out_free),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

FILE: hw/rtl/qfd_checker.sv
// Port-level checks for the queue with delete by value, bound to the top level.
module qfd_checker #(
  parameter int DEPTH = qfd_pkg::DEPTH
) (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input qfd_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input qfd_pkg::rsp_t rsp
);

  // A stalled response holds.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed");

  // The engine is busy in the cycle after it takes a request.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken in back-to-back cycles");

  // Only a successful dequeue returns a word.
  a_fail_no_word: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != qfd_pkg::ST_OK |-> rsp.out_value == '0)
    else $error("failing response carries a word");

  // Full and empty statuses agree with the reported length.
  a_full_len: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == qfd_pkg::ST_FULL |-> rsp.length == qfd_pkg::LEN_W'(DEPTH))
    else $error("full status with a short queue");

  a_empty_len: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == qfd_pkg::ST_EMPTY |-> rsp.length == '0)
    else $error("empty status with entries held");

endmodule

bind fifo_queue_with_delete_by_value_top qfd_checker #(.DEPTH(DEPTH)) u_qfd_checker (.*);
